// ===== rtl/core/hfcd_pkg.sv =====
package hfcd_pkg;

    localparam int unsigned AddrWidth = 5;
    localparam int unsigned QuotWidth = 48;
    localparam int unsigned NumWidth = 89;
    localparam int unsigned DenWidth = 68;

    localparam logic [AddrWidth-1:0] RegGlobalScale = 5'd0;
    localparam logic [AddrWidth-1:0] RegQuantBiasX = 5'd4;
    localparam logic [AddrWidth-1:0] RegQuantBiasY = 5'd8;
    localparam logic [AddrWidth-1:0] RegQuantBiasB = 5'd12;
    localparam logic [AddrWidth-1:0] RegBiasNumerator = 5'd16;
    localparam logic [AddrWidth-1:0] RegXMatrixScale = 5'd20;
    localparam logic [AddrWidth-1:0] RegBMatrixScale = 5'd24;

    localparam logic [1:0] ChanX = 2'd0;
    localparam logic [1:0] ChanY = 2'd1;
    localparam logic [1:0] ChanB = 2'd2;

    function automatic logic [10:0] scale_num(input logic [2:0] k);
        logic [10:0] v;
        case (k)
            3'd0: v = 11'd25;
            3'd1: v = 11'd5;
            3'd2: v = 11'd1;
            3'd3: v = 11'd4;
            3'd4: v = 11'd16;
            3'd5: v = 11'd64;
            3'd6: v = 11'd256;
            default: v = 11'd1024;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] scale_den(input logic [2:0] k);
        logic [11:0] v;
        case (k)
            3'd0: v = 12'd16;
            3'd1: v = 12'd4;
            3'd2: v = 12'd1;
            3'd3: v = 12'd5;
            3'd4: v = 12'd25;
            3'd5: v = 12'd125;
            3'd6: v = 12'd625;
            default: v = 12'd3125;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/hf_coefficient_dequantizer.sv =====
// An accepted input transaction reaches the output through stages 1 to 4, the divider and the output register.
// Throughput: one transaction per cycle while the output is not stalled; the 48-stage restoring divider sets the depth.
// The whole pipeline stalls together while a finished result waits on the output.
// Reset (i_rst_n low, synchronous) clears every valid bit and restores the register
// defaults; payload registers are not reset.
module hf_coefficient_dequantizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [15:0]                 i_coefficient,
    input  logic [31:0]                        i_weight,
    input  logic [15:0]                        i_block_multiplier,
    input  logic [1:0]                         i_channel,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [47:0]                 o_dequantized,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hfcd_pkg::AddrWidth-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int unsigned QW = hfcd_pkg::QuotWidth;
    localparam int unsigned DW = hfcd_pkg::DenWidth;
    localparam int unsigned NW = hfcd_pkg::NumWidth;

    logic [15:0] r_global_scale, r_bias_x, r_bias_y, r_bias_b, r_bias_num;
    logic [2:0]  r_x_scale, r_b_scale;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_scale <= 16'd1;
            r_bias_x       <= 16'd61954;
            r_bias_y       <= 16'd60944;
            r_bias_b       <= 16'd62263;
            r_bias_num     <= 16'd9503;
            r_x_scale      <= 3'd2;
            r_b_scale      <= 3'd2;
        end else if (cfg_wr) begin
            unique case (paddr)
                hfcd_pkg::RegGlobalScale:   r_global_scale <= pwdata[15:0];
                hfcd_pkg::RegQuantBiasX:    r_bias_x <= pwdata[15:0];
                hfcd_pkg::RegQuantBiasY:    r_bias_y <= pwdata[15:0];
                hfcd_pkg::RegQuantBiasB:    r_bias_b <= pwdata[15:0];
                hfcd_pkg::RegBiasNumerator: r_bias_num <= pwdata[15:0];
                hfcd_pkg::RegXMatrixScale:  r_x_scale <= pwdata[2:0];
                hfcd_pkg::RegBMatrixScale:  r_b_scale <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            hfcd_pkg::RegGlobalScale:   prdata = {16'd0, r_global_scale};
            hfcd_pkg::RegQuantBiasX:    prdata = {16'd0, r_bias_x};
            hfcd_pkg::RegQuantBiasY:    prdata = {16'd0, r_bias_y};
            hfcd_pkg::RegQuantBiasB:    prdata = {16'd0, r_bias_b};
            hfcd_pkg::RegBiasNumerator: prdata = {16'd0, r_bias_num};
            hfcd_pkg::RegXMatrixScale:  prdata = {29'd0, r_x_scale};
            hfcd_pkg::RegBMatrixScale:  prdata = {29'd0, r_b_scale};
            default:                    prdata = 32'd0;
        endcase
    end

    logic en;
    logic r_out_valid;
    assign en = !r_out_valid || i_ready;
    assign o_ready = en;

    // Stage 1: magnitude, bias and scale selection and the numerator term a.
    logic        neg_in;
    logic [15:0] mag_in, bias_sel;
    logic [2:0]  scale_sel;
    logic        scaled_chan;
    logic [46:0] n_a;

    always_comb begin
        neg_in = i_coefficient[15];
        mag_in = neg_in ? 16'(-i_coefficient) : 16'(i_coefficient);
        scaled_chan = 1'b0;
        scale_sel = 3'd2;
        bias_sel = r_bias_y;
        if (i_channel == hfcd_pkg::ChanX) begin
            bias_sel = r_bias_x;
            scale_sel = r_x_scale;
            scaled_chan = 1'b1;
        end else if (i_channel == hfcd_pkg::ChanB) begin
            bias_sel = r_bias_b;
            scale_sel = r_b_scale;
            scaled_chan = 1'b1;
        end
        if (mag_in <= 16'd1) begin
            n_a = 47'(mag_in * bias_sel);
        end else begin
            n_a = {31'(mag_in * mag_in), 16'd0} - 47'(r_bias_num);
        end
    end

    logic        r_v1, r_neg1;
    logic [46:0] r_a1;
    logic [15:0] r_e1, r_mult1;
    logic [31:0] r_w1;
    logic [10:0] r_sn1;
    logic [11:0] r_sd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
        if (en) begin
            r_neg1  <= neg_in;
            r_a1    <= n_a;
            r_e1    <= (mag_in <= 16'd1) ? 16'd1 : mag_in;
            r_mult1 <= i_block_multiplier;
            r_w1    <= i_weight;
            r_sn1   <= scaled_chan ? hfcd_pkg::scale_num(scale_sel) : 11'd1;
            r_sd1   <= scaled_chan ? hfcd_pkg::scale_den(scale_sel) : 12'd1;
        end
    end

    // Stage 2: partial products of a times weight, divisor and e times sd.
    logic        r_v2, r_neg2;
    logic [61:0] r_pl2, r_ph2;
    logic [31:0] r_div2;
    logic [27:0] r_esd2;
    logic [10:0] r_sn2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_neg2 <= r_neg1;
            r_pl2  <= 62'(r_a1 * r_w1[15:0]);
            r_ph2  <= 62'(r_a1 * r_w1[31:16]);
            r_div2 <= 32'(r_global_scale * r_mult1);
            r_esd2 <= 28'(r_e1 * r_sd1);
            r_sn2  <= r_sn1;
        end
    end

    // Stage 3: full product and the divisor chain.
    logic        r_v3, r_neg3, r_dz3;
    logic [77:0] r_p3;
    logic [59:0] r_dd3;
    logic [10:0] r_sn3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
        if (en) begin
            r_neg3 <= r_neg2;
            r_p3   <= 78'(r_pl2) + {r_ph2, 16'd0};
            r_dd3  <= 60'(r_esd2 * r_div2);
            r_dz3  <= (r_div2 == 32'd0);
            r_sn3  <= r_sn2;
        end
    end

    // Stage 4: numerator times the scale numerator, and the denominator times 256.
    logic          r_v4, r_neg4, r_dz4;
    logic [NW-1:0] r_num4;
    logic [DW-1:0] r_den4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
        if (en) begin
            r_neg4 <= r_neg3;
            r_dz4  <= r_dz3;
            r_num4 <= NW'(r_p3 * r_sn3);
            r_den4 <= {r_dd3, 8'd0};
        end
    end

    // Divider: index 0 holds the overflow check, then one quotient bit a stage.
    logic          r_dv   [0:QW];
    logic          r_dneg [0:QW];
    logic          r_dzero[0:QW];
    logic          r_dsat [0:QW];
    logic [DW-1:0] r_rem  [0:QW];
    logic [DW-1:0] r_den  [0:QW];
    logic [QW-1:0] r_q    [0:QW];
    logic [QW-1:0] r_nl   [0:QW];

    logic [NW-QW-1:0] num_hi;
    assign num_hi = r_num4[NW-1:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v4;
        end
        if (en) begin
            r_dneg[0]  <= r_neg4;
            r_dzero[0] <= (r_num4 == '0);
            r_dsat[0]  <= r_dz4 || (DW'(num_hi) >= r_den4);
            r_rem[0]   <= DW'(num_hi);
            r_den[0]   <= r_den4;
            r_q[0]     <= '0;
            r_nl[0]    <= r_num4[QW-1:0];
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DW:0]   t;
        logic          ge;
        logic [DW-1:0] n_rem;
        always_comb begin
            t = {r_rem[k], r_nl[k][QW-1]};
            ge = (t >= {1'b0, r_den[k]});
            n_rem = ge ? DW'(t - {1'b0, r_den[k]}) : DW'(t);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
            if (en) begin
                r_dneg[k+1]  <= r_dneg[k];
                r_dzero[k+1] <= r_dzero[k];
                r_dsat[k+1]  <= r_dsat[k];
                r_rem[k+1]   <= n_rem;
                r_den[k+1]   <= r_den[k];
                r_q[k+1]     <= {r_q[k][QW-2:0], ge};
                r_nl[k+1]    <= {r_nl[k][QW-2:0], 1'b0};
            end
        end
    end

    // Output: rounding, saturation and sign.
    logic [QW-1:0] lim, mag_out, n_res;
    logic          rnd;

    always_comb begin
        lim = r_dneg[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        rnd = ({r_rem[QW], 1'b0} >= {1'b0, r_den[QW]});
        if (r_dzero[QW]) begin
            mag_out = '0;
        end else if (r_dsat[QW] || (r_q[QW] >= lim)) begin
            mag_out = lim;
        end else begin
            mag_out = r_q[QW] + QW'(rnd);
        end
        n_res = r_dneg[QW] ? QW'(-mag_out) : mag_out;
    end

    logic signed [47:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv[QW];
        end
        if (en) begin
            r_out <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_dequantized = r_out;

`ifndef SYNTH
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!r_out_valid || i_ready))
        else $error("ready does not follow the output stall");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v1)
        else $error("accepted transaction lost at entry");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_dv[QW] == $past(r_dv[QW])))
        else $error("divider moved during a stall");
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_dv[QW] && r_dzero[QW]) |=> (o_dequantized == 48'sd0))
        else $error("zero numerator gave a nonzero result");
`endif

endmodule

// ===== test/tb_hf_coefficient_dequantizer.sv =====
`timescale 1ns / 1ps

module tb_hf_coefficient_dequantizer;

    localparam int unsigned Latency = 53;
    localparam int unsigned WatchdogLimit = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_coefficient;
    logic [31:0]        i_weight;
    logic [15:0]        i_block_multiplier;
    logic [1:0]         i_channel;
    logic               o_valid;
    logic               i_ready;
    logic signed [47:0] o_dequantized;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [hfcd_pkg::AddrWidth-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    logic [15:0] global_scale_q;
    logic [15:0] bias_x_q;
    logic [15:0] bias_y_q;
    logic [15:0] bias_b_q;
    logic [15:0] bias_numerator_q;
    logic [2:0]  x_scale_q;
    logic [2:0]  b_scale_q;

    logic [47:0] pending_dequant[$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned hold_left;
    int unsigned stall_left;
    bit          steady;

    hf_coefficient_dequantizer DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_coefficient      (i_coefficient),
        .i_weight           (i_weight),
        .i_block_multiplier (i_block_multiplier),
        .i_channel          (i_channel),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_dequantized      (o_dequantized),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The ratio 0.8^(k-2) as a numerator and denominator pair.
    function automatic logic [10:0] scale_num_of(logic [2:0] k);
        logic [10:0] nums[8];
        nums = '{11'd25, 11'd5, 11'd1, 11'd4, 11'd16, 11'd64, 11'd256, 11'd1024};
        return nums[k];
    endfunction

    function automatic logic [11:0] scale_den_of(logic [2:0] k);
        logic [11:0] dens[8];
        dens = '{12'd16, 12'd4, 12'd1, 12'd5, 12'd25, 12'd125, 12'd625, 12'd3125};
        return dens[k];
    endfunction

    function automatic logic [47:0] predict_dequant(logic signed [15:0] coef,
            logic [31:0] weight, logic [15:0] mult, logic [1:0] chan);
        logic        neg;
        logic [16:0] mag;
        logic [15:0] bias;
        logic [10:0] sn;
        logic [11:0] sd;
        logic [127:0] a;
        logic [127:0] e;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] rem;
        logic [47:0]  limit;
        logic [47:0]  mag_res;
        neg = coef[15];
        mag = neg ? 17'(-$signed({coef[15], coef})) : {1'b0, coef};
        sn = 11'd1;
        sd = 12'd1;
        if (chan == hfcd_pkg::ChanX) begin
            bias = bias_x_q;
            sn = scale_num_of(x_scale_q);
            sd = scale_den_of(x_scale_q);
        end else if (chan == hfcd_pkg::ChanB) begin
            bias = bias_b_q;
            sn = scale_num_of(b_scale_q);
            sd = scale_den_of(b_scale_q);
        end else begin
            bias = bias_y_q;
        end
        if (mag <= 17'd1) begin
            a = 128'(mag) * 128'(bias);
            e = 128'd1;
        end else begin
            a = ((128'(mag) * 128'(mag)) << 16) - 128'(bias_numerator_q);
            e = 128'(mag);
        end
        num = a * 128'(weight) * 128'(sn);
        limit = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        if (num == 128'd0) begin
            mag_res = 48'd0;
        end else if (128'(global_scale_q) * 128'(mult) == 128'd0) begin
            mag_res = limit;
        end else begin
            den = 128'd256 * e * 128'(sd) * 128'(global_scale_q) * 128'(mult);
            quo = num / den;
            rem = num % den;
            if (quo >= 128'(limit)) begin
                mag_res = limit;
            end else if ((rem << 1) >= den) begin
                mag_res = quo[47:0] + 48'd1;
            end else begin
                mag_res = quo[47:0];
            end
        end
        return neg ? 48'd0 - mag_res : mag_res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_dequant.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected result transaction: %h", o_dequantized);
                    end
                end else begin
                    if (o_dequantized !== pending_dequant[0]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch on dequantized: expected %h, actual %h",
                                pending_dequant[0], o_dequantized);
                        end
                    end
                    void'(pending_dequant.pop_front());
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                i_ready <= (stall_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("tb_hf_coefficient_dequantizer NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [hfcd_pkg::AddrWidth-1:0] addr, logic [15:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            hfcd_pkg::RegGlobalScale:   global_scale_q = value;
            hfcd_pkg::RegQuantBiasX:    bias_x_q = value;
            hfcd_pkg::RegQuantBiasY:    bias_y_q = value;
            hfcd_pkg::RegQuantBiasB:    bias_b_q = value;
            hfcd_pkg::RegBiasNumerator: bias_numerator_q = value;
            hfcd_pkg::RegXMatrixScale:  x_scale_q = value[2:0];
            hfcd_pkg::RegBMatrixScale:  b_scale_q = value[2:0];
            default: ;
        endcase
    endtask

    task automatic send_coefficient(logic signed [15:0] coef, logic [31:0] weight,
            logic [15:0] mult, logic [1:0] chan);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_coefficient <= coef;
        i_weight <= weight;
        i_block_multiplier <= mult;
        i_channel <= chan;
        do @(posedge i_clk); while (!o_ready);
        pending_dequant.push_back(predict_dequant(coef, weight, mult, chan));
    endtask

    task automatic send_random();
        logic signed [15:0] coef;
        logic [31:0] weight;
        logic [15:0] mult;
        int unsigned r;
        r = $urandom_range(0, 9);
        coef = (r < 4) ? 16'($signed($urandom_range(0, 4)) - 2) : 16'($urandom);
        weight = (r[0]) ? $urandom : 32'($urandom_range(0, 32'h0400_0000));
        mult = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                           : 16'($urandom_range(1, 16));
        send_coefficient(coef, weight, mult, 2'($urandom_range(0, 2)));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_dequant.size() != 0) @(posedge i_clk);
        repeat (Latency + 6) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [1:0] chan;
        for (int c = 0; c < 3; c++) begin
            chan = 2'(c);
            send_coefficient(16'sd0, 32'hFFFF_FFFF, 16'd1, chan);
            send_coefficient(16'sd1, 32'h0100_0000, 16'd1, chan);
            send_coefficient(-16'sd1, 32'hFFFF_FFFF, 16'd65535, chan);
            send_coefficient(16'sd2, 32'h0100_0000, 16'd3, chan);
            send_coefficient(-16'sd2, 32'd0, 16'd7, chan);
            send_coefficient(16'sd32767, 32'hFFFF_FFFF, 16'd1, chan);
            send_coefficient(16'sh8000, 32'hFFFF_FFFF, 16'd1, chan);
        end
        send_coefficient(16'sh8000, 32'd1, 16'd65535, hfcd_pkg::ChanX);
        send_coefficient(16'sd32767, 32'd1, 16'd65535, hfcd_pkg::ChanB);
        send_coefficient(16'sd3, 32'h5555_AAAA, 16'hAAAA, hfcd_pkg::ChanY);
        drain();
    endtask

    task automatic test_register_sweep();
        for (int s = 0; s < 8; s++) begin
            case (s)
                0: begin
                    write_reg(hfcd_pkg::RegGlobalScale, 16'd65535);
                    write_reg(hfcd_pkg::RegQuantBiasX, 16'd0);
                    write_reg(hfcd_pkg::RegQuantBiasY, 16'd65535);
                    write_reg(hfcd_pkg::RegQuantBiasB, 16'd0);
                    write_reg(hfcd_pkg::RegBiasNumerator, 16'd65535);
                end
                1: begin
                    write_reg(hfcd_pkg::RegGlobalScale, 16'd1);
                    write_reg(hfcd_pkg::RegQuantBiasX, 16'd65535);
                    write_reg(hfcd_pkg::RegQuantBiasY, 16'd0);
                    write_reg(hfcd_pkg::RegQuantBiasB, 16'd65535);
                    write_reg(hfcd_pkg::RegBiasNumerator, 16'd0);
                end
                default: begin
                    write_reg(hfcd_pkg::RegGlobalScale, 16'($urandom_range(1, 300)));
                    write_reg(hfcd_pkg::RegQuantBiasX, 16'($urandom));
                    write_reg(hfcd_pkg::RegQuantBiasY, 16'($urandom));
                    write_reg(hfcd_pkg::RegQuantBiasB, 16'($urandom));
                    write_reg(hfcd_pkg::RegBiasNumerator, 16'($urandom));
                end
            endcase
            write_reg(hfcd_pkg::RegXMatrixScale, 16'(s));
            write_reg(hfcd_pkg::RegBMatrixScale, 16'(7 - s));
            steady = (s == 3);
            repeat (180) send_random();
            steady = 1'b0;
            drain();
        end
    endtask

    task automatic test_output_backpressure();
        write_reg(hfcd_pkg::RegGlobalScale, 16'd2);
        write_reg(hfcd_pkg::RegXMatrixScale, 16'd2);
        write_reg(hfcd_pkg::RegBMatrixScale, 16'd5);
        hold_left = 300;
        steady = 1'b1;
        repeat (120) send_random();
        steady = 1'b0;
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_coefficient = '0;
        i_weight = '0;
        i_block_multiplier = 16'd1;
        i_channel = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        hold_left = 0;
        stall_left = 0;
        steady = 1'b0;
        global_scale_q = 16'd1;
        bias_x_q = 16'd61954;
        bias_y_q = 16'd60944;
        bias_b_q = 16'd62263;
        bias_numerator_q = 16'd9503;
        x_scale_q = 3'd2;
        b_scale_q = 3'd2;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_sweep();
        test_output_backpressure();
        if (mismatch_count == 0 && pending_dequant.size() == 0) begin
            $display("tb_hf_coefficient_dequantizer OK");
        end else begin
            $display("tb_hf_coefficient_dequantizer NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/hfcd_pkg.sv
rtl/core/hf_coefficient_dequantizer.sv
test/tb_hf_coefficient_dequantizer.sv
